@@ design/i2cm_pkg.sv @@
// Shared types, register map codes and defaults for the I2C write master.
`default_nettype none
package i2cm_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int ADDR_BITS_DEF  = 7;
    localparam logic [15:0] PHASE_CYCLES_RST = 16'd1000;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // register file indexes
    localparam logic [2:0] REG_CTRL = 3'd0;
    localparam logic [2:0] REG_STAT = 3'd1;
    localparam logic [2:0] REG_DLEN = 3'd2;
    localparam logic [2:0] REG_ADDR = 3'd3;
    localparam logic [2:0] REG_FIFO = 3'd4;

    // control and status bit positions
    localparam int CTRL_READ_BIT   = 0;
    localparam int CTRL_CLEAR_LO   = 4;
    localparam int CTRL_CLEAR_HI   = 5;
    localparam int CTRL_START_BIT  = 7;
    localparam int CTRL_ENABLE_BIT = 15;
    localparam int STAT_DONE_BIT   = 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  byte_addr;
        logic [2:0]  access_bytes;
        logic [31:0] write_data;
        logic [15:0] tick_cycles;
        logic        sda_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        sda_out;
        logic        scl_out;
        logic        busy_res;
        logic        ack_missing;
        logic        fifo_underrun;
        logic        fifo_overflow;
    } t_out_item;

endpackage
`default_nettype wire

@@ design/i2c_master_bit_bang_controller_core.sv @@
// Top level of the I2C write master: register file, transmit FIFO and bit sequencer.
// An item transferred in is registered in the input stage, then in the result register.
// Throughput: one item per cycle, one update pass from input to result register;
// a stalled result holds the input stage and stalls the input in the same cycle.
// Reset (i_rst_n low, synchronous): register file zero, FIFO empty, lines high,
// sequencer at the start bit, phase_cycles back to 1000. FIFO storage is not cleared.
`default_nettype none
module i2c_master_bit_bang_controller_core #(
    parameter int FIFO_DEPTH = i2cm_pkg::FIFO_DEPTH_DEF,
    parameter int ADDR_BITS  = i2cm_pkg::ADDR_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // item channel in
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire i2cm_pkg::t_in_item i_in,
    // result channel out
    output logic                 o_valid,
    input  wire                  i_stall,
    output i2cm_pkg::t_out_item  o_out,
    // configuration port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    // sequencer codes
    localparam logic [2:0] PS_START = 3'd0;
    localparam logic [2:0] PS_ADDR  = 3'd1;
    localparam logic [2:0] PS_RW    = 3'd2;
    localparam logic [2:0] PS_ACK1  = 3'd3;
    localparam logic [2:0] PS_DATA  = 3'd4;
    localparam logic [2:0] PS_ACK2  = 3'd5;
    localparam logic [2:0] PS_STOP  = 3'd6;

    // SCL phase codes
    localparam logic [1:0] PH_CHANGE = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_LOW    = 2'd2;

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                r_in_valid;
    i2cm_pkg::t_in_item  r_in;
    logic                r_out_valid;
    i2cm_pkg::t_out_item r_out;
    i2cm_pkg::t_out_item n_out;

    // ------------------------------------------------------------------
    // Block state
    // ------------------------------------------------------------------
    logic [15:0]          r_phase_cycles;
    logic [7:0][31:0]     r_regs,       n_regs;
    logic [7:0]           r_fifo [FIFO_DEPTH];
    logic [7:0]           r_head_data;
    logic [PTR_W-1:0]     r_head,       n_head;
    logic [CNT_W-1:0]     r_count,      n_count;
    logic [15:0]          r_acc,        n_acc;
    logic [1:0]           r_clk_phase,  n_clk_phase;
    logic [2:0]           r_pstate,     n_pstate;
    logic [3:0]           r_bit,        n_bit;
    logic [15:0]          r_bytes_left, n_bytes_left;
    logic                 r_read_flag,  n_read_flag;
    logic                 r_active,     n_active;
    logic                 r_sda,        n_sda;
    logic                 r_scl,        n_scl;
    logic [ADDR_BITS-1:0] r_slave,      n_slave;

    logic             adv;        // result register free for the item in the input stage
    logic             proc;       // item in the input stage is handled this cycle
    logic             push_we;
    logic [7:0]       push_data;
    logic [PTR_W-1:0] wr_slot;
    logic [SUM_W-1:0] slot_sum;
    logic [PTR_W-1:0] head_inc;

    // ------------------------------------------------------------------
    // Handshake: the input stage hands over when the result register is
    // empty or its transfer completes this cycle.
    // ------------------------------------------------------------------
    assign adv     = !r_out_valid || !i_stall;
    assign proc    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Tail slot and head successor, with wrap for any depth.
    assign slot_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign wr_slot  = (slot_sum >= SUM_W'(FIFO_DEPTH)) ?
                      PTR_W'(slot_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(slot_sum);
    assign head_inc = (r_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // ------------------------------------------------------------------
    // Configuration port: only phase_cycles lives here.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_phase_cycles};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_cycles <= i2cm_pkg::PHASE_CYCLES_RST;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_phase_cycles <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // One pass over the item: register write, register read or time tick; other kinds report levels only.
    // ------------------------------------------------------------------
    always_comb begin
        logic [2:0]  eff_n;
        logic [2:0]  reg_sel;
        logic [5:0]  a;
        logic [31:0] ctrl;
        logic [15:0] len;
        logic [16:0] sum;
        logic [31:0] rdata;
        logic        f_ack;
        logic        f_under;
        logic        f_over;

        n_regs       = r_regs;
        n_head       = r_head;
        n_count      = r_count;
        n_acc        = r_acc;
        n_clk_phase  = r_clk_phase;
        n_pstate     = r_pstate;
        n_bit        = r_bit;
        n_bytes_left = r_bytes_left;
        n_read_flag  = r_read_flag;
        n_active     = r_active;
        n_sda        = r_sda;
        n_scl        = r_scl;
        n_slave      = r_slave;
        push_we      = 1'b0;
        push_data    = '0;
        rdata        = '0;
        f_ack        = 1'b0;
        f_under      = 1'b0;
        f_over       = 1'b0;
        ctrl         = '0;
        len          = '0;
        sum          = '0;
        a            = '0;

        eff_n   = (r_in.access_bytes > 3'd4) ? 3'd4 : r_in.access_bytes;
        reg_sel = r_in.byte_addr[4:2];

        if (proc) begin
            case (r_in.kind)
                i2cm_pkg::KIND_WRITE: begin
                    // little endian byte lanes, bytes past the file dropped
                    for (int i = 0; i < 4; i++) begin
                        a = {1'b0, r_in.byte_addr} + 6'(i);
                        if (3'(i) < eff_n && !a[5]) begin
                            n_regs[a[4:2]][{a[1:0], 3'b000} +: 8] = r_in.write_data[i*8 +: 8];
                        end
                    end
                    if (reg_sel == i2cm_pkg::REG_FIFO) begin
                        if (r_count >= CNT_W'(FIFO_DEPTH)) begin
                            f_over = 1'b1;
                        end else begin
                            push_we   = 1'b1;
                            push_data = n_regs[i2cm_pkg::REG_FIFO][7:0];
                            n_count   = r_count + 1'b1;
                        end
                    end else if (reg_sel == i2cm_pkg::REG_CTRL) begin
                        ctrl = n_regs[i2cm_pkg::REG_CTRL];
                        if (ctrl[i2cm_pkg::CTRL_CLEAR_HI:i2cm_pkg::CTRL_CLEAR_LO] != 2'b00) begin
                            n_head  = '0;
                            n_count = '0;
                        end
                        if (ctrl[i2cm_pkg::CTRL_ENABLE_BIT] && ctrl[i2cm_pkg::CTRL_START_BIT]) begin
                            len          = n_regs[i2cm_pkg::REG_DLEN][15:0];
                            n_pstate     = PS_START;
                            n_slave      = n_regs[i2cm_pkg::REG_ADDR][ADDR_BITS-1:0];
                            n_bit        = 4'(ADDR_BITS);
                            n_bytes_left = (len == 16'd0) ? 16'd1 : len;
                            n_read_flag  = ctrl[i2cm_pkg::CTRL_READ_BIT];
                            n_regs[i2cm_pkg::REG_STAT][i2cm_pkg::STAT_DONE_BIT] = 1'b0;
                            n_sda        = 1'b1;
                            n_scl        = 1'b1;
                            n_acc        = '0;
                            n_active     = 1'b1;
                            n_clk_phase  = PH_CHANGE;
                        end
                    end
                end
                i2cm_pkg::KIND_READ: begin
                    // FIFO read loads the head byte and pops it
                    if (reg_sel == i2cm_pkg::REG_FIFO && r_count != '0) begin
                        n_regs[i2cm_pkg::REG_FIFO] = {24'd0, r_head_data};
                        n_head  = head_inc;
                        n_count = r_count - 1'b1;
                    end
                    for (int i = 0; i < 4; i++) begin
                        a = {1'b0, r_in.byte_addr} + 6'(i);
                        if (3'(i) < eff_n && !a[5]) begin
                            rdata[i*8 +: 8] = n_regs[a[4:2]][{a[1:0], 3'b000} +: 8];
                        end
                    end
                end
                i2cm_pkg::KIND_TICK: begin
                    if (r_active) begin
                        sum = {1'b0, r_acc} + {1'b0, r_in.tick_cycles};
                        if (sum < {1'b0, r_phase_cycles}) begin
                            n_acc = sum[15:0];
                        end else begin
                            n_acc = '0;
                            case (r_clk_phase)
                                PH_HIGH: begin
                                    n_scl       = 1'b1;
                                    n_clk_phase = PH_LOW;
                                end
                                PH_LOW: begin
                                    n_scl       = 1'b0;
                                    n_clk_phase = PH_CHANGE;
                                end
                                default: begin
                                    n_clk_phase = PH_HIGH;
                                    case (r_pstate)
                                        PS_START: begin
                                            n_sda    = 1'b0;
                                            n_pstate = PS_ADDR;
                                        end
                                        PS_ADDR: begin
                                            n_bit = r_bit - 1'b1;
                                            n_sda = (r_slave >> n_bit) != '0 ?
                                                    ((r_slave >> n_bit) & ADDR_BITS'(1)) != '0 :
                                                    1'b0;
                                            if (n_bit == 4'd0) begin
                                                n_pstate = PS_RW;
                                            end
                                        end
                                        PS_RW: begin
                                            n_sda    = r_read_flag;
                                            n_pstate = PS_ACK1;
                                        end
                                        PS_ACK1: begin
                                            f_ack    = r_in.sda_in;
                                            n_bit    = 4'd8;
                                            n_pstate = PS_DATA;
                                        end
                                        PS_DATA: begin
                                            n_bit = r_bit - 1'b1;
                                            if (r_count == '0) begin
                                                // nothing queued: send zero and flag it
                                                f_under = 1'b1;
                                                n_sda   = 1'b0;
                                            end else begin
                                                n_sda = r_head_data[n_bit[2:0]];
                                            end
                                            if (n_bit == 4'd0) begin
                                                if (r_count != '0) begin
                                                    n_head  = head_inc;
                                                    n_count = r_count - 1'b1;
                                                end
                                                n_pstate = PS_ACK2;
                                            end
                                        end
                                        PS_ACK2: begin
                                            f_ack        = r_in.sda_in;
                                            n_bytes_left = r_bytes_left - 1'b1;
                                            if (n_bytes_left != 16'd0) begin
                                                n_bit    = 4'd8;
                                                n_pstate = PS_DATA;
                                            end else begin
                                                n_pstate = PS_STOP;
                                            end
                                        end
                                        default: begin
                                            // stop condition, transfer complete
                                            n_scl    = 1'b1;
                                            n_sda    = 1'b1;
                                            n_active = 1'b0;
                                            n_regs[i2cm_pkg::REG_STAT][i2cm_pkg::STAT_DONE_BIT] =
                                                1'b1;
                                            n_regs[i2cm_pkg::REG_CTRL][i2cm_pkg::CTRL_START_BIT] =
                                                1'b0;
                                            n_regs[i2cm_pkg::REG_CTRL][i2cm_pkg::CTRL_CLEAR_HI:
                                                                      i2cm_pkg::CTRL_CLEAR_LO] =
                                                2'b00;
                                        end
                                    endcase
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    // unused kind: report levels only
                end
            endcase
        end

        n_out.read_data     = rdata;
        n_out.sda_out       = n_sda;
        n_out.scl_out       = n_scl;
        n_out.busy_res      = n_active;
        n_out.ack_missing   = f_ack;
        n_out.fifo_underrun = f_under;
        n_out.fifo_overflow = f_over;
    end

    // ------------------------------------------------------------------
    // Control state and pipeline valids
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_regs       <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_acc        <= '0;
            r_clk_phase  <= PH_CHANGE;
            r_pstate     <= PS_START;
            r_bit        <= '0;
            r_bytes_left <= '0;
            r_read_flag  <= 1'b0;
            r_active     <= 1'b0;
            r_sda        <= 1'b1;
            r_scl        <= 1'b1;
            r_slave      <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_regs       <= n_regs;
            r_head       <= n_head;
            r_count      <= n_count;
            r_acc        <= n_acc;
            r_clk_phase  <= n_clk_phase;
            r_pstate     <= n_pstate;
            r_bit        <= n_bit;
            r_bytes_left <= n_bytes_left;
            r_read_flag  <= n_read_flag;
            r_active     <= n_active;
            r_sda        <= n_sda;
            r_scl        <= n_scl;
            r_slave      <= n_slave;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_in;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Transmit FIFO storage. r_head_data always shows the entry at the
    // head; a push into an empty FIFO is forwarded straight into it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (push_we) begin
            r_fifo[wr_slot] <= push_data;
        end
        r_head_data <= (push_we && r_count == '0) ? push_data : r_fifo[n_head];
    end

endmodule
`default_nettype wire

@@ design/i2cm_checker.sv @@
// Port-level checker for the I2C write master, bound to the top level.
`default_nettype none
module i2cm_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_stall,
    input wire                  o_valid,
    input wire                  i_stall,
    input wire i2cm_pkg::t_out_item o_out
);

    // a held result does not move
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");

    // input side never stalls while the result register is empty
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result pending");

    // outside a transfer both lines are released high
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.busy_res |-> o_out.sda_out && o_out.scl_out)
        else $error("line driven low while idle");

    // ack and underrun come from different bit slots, both inside a transfer
    a_flag_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.ack_missing || o_out.fifo_underrun) |->
            o_out.busy_res && !(o_out.ack_missing && o_out.fifo_underrun))
        else $error("bit slot flags inconsistent");

    // overflow only comes from a write, which returns no read data
    a_overflow_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.fifo_overflow |-> o_out.read_data == 32'd0)
        else $error("overflow flagged on a read result");

endmodule

bind i2c_master_bit_bang_controller_core i2cm_checker u_i2cm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
`default_nettype wire
